// ===== rtl/core/cvw_pkg.sv =====
// shared constants and types for the 3x3 valid-window convolution block
package cvw_pkg;

   localparam int IMG_WIDTH  = 64;
   localparam int IMG_HEIGHT = 64;

   localparam int KSIZE     = 3;
   localparam int PIX_W     = 16;
   localparam int COEF_W    = 16;
   localparam int KROW_W    = KSIZE * COEF_W;
   localparam int CNT_W     = 12;
   localparam int ADDR_W    = $clog2(IMG_WIDTH);
   localparam int LINE_W    = 2 * PIX_W;
   localparam int PROD_W    = PIX_W + COEF_W;
   localparam int PSUM_W    = PROD_W + 2;
   localparam int SUM_W     = PROD_W + 4;
   localparam int FILT_W    = 35;
   localparam int CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0] COL_LAST = CNT_W'(IMG_WIDTH - 1);
   localparam logic [CNT_W-1:0] ROW_LAST = CNT_W'(IMG_HEIGHT - 1);
   localparam logic [CNT_W-1:0] BORDER   = CNT_W'(2);

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROW0 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROW1 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROW2 = CSR_IDX_W'(2);

   // [row][column] of pixels, column 2 is the newest
   typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0]  window_type;
   // [row][column] of coefficients, column 0 in the low bits of a row
   typedef logic [KSIZE-1:0][KSIZE-1:0][COEF_W-1:0] kernel_type;
   typedef logic signed [KSIZE-1:0][PSUM_W-1:0]     psum_type;

   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] row;
      logic [CNT_W-1:0] col;
      logic             last;
   } meta_type;

endpackage

// ===== rtl/core/cvw_ram.sv =====
// generic single-port-write ram with registered read
module cvw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/cvw_window.sv =====
// line store and 3x3 window shift with result position tagging
module cvw_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          accept,
   input  logic [cvw_pkg::PIX_W-1:0]     pixel,
   input  logic [cvw_pkg::CNT_W-1:0]     row,
   input  logic [cvw_pkg::CNT_W-1:0]     col,
   output cvw_pkg::window_type           window,
   output cvw_pkg::meta_type             meta
);

   logic                          s1_valid_ff;
   logic [cvw_pkg::PIX_W-1:0]     s1_pixel_ff;
   logic [cvw_pkg::CNT_W-1:0]     s1_row_ff;
   logic [cvw_pkg::CNT_W-1:0]     s1_col_ff;

   logic                          fwd_hit_ff;
   logic                          fwd_hit_in;
   logic [cvw_pkg::LINE_W-1:0]    fwd_data_ff;

   logic [cvw_pkg::LINE_W-1:0]    rd_data;
   logic [cvw_pkg::LINE_W-1:0]    line;
   logic [cvw_pkg::LINE_W-1:0]    wr_data;
   logic                          wr_en;
   logic [cvw_pkg::PIX_W-1:0]     above1;
   logic [cvw_pkg::PIX_W-1:0]     above2;

   cvw_pkg::window_type           window_ff;
   cvw_pkg::window_type           window_in;
   cvw_pkg::meta_type             meta_ff;
   cvw_pkg::meta_type             meta_in;

   // entry c holds {row-2 pixel, row-1 pixel} of column c
   cvw_ram #(
      .WIDTH (cvw_pkg::LINE_W),
      .DEPTH (cvw_pkg::IMG_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff[cvw_pkg::ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (col[cvw_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // a write in the same cycle as a read of the same column bypasses the ram
   assign line    = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign above1  = line[cvw_pkg::PIX_W-1:0];
   assign above2  = line[cvw_pkg::LINE_W-1:cvw_pkg::PIX_W];
   assign wr_data = {above1, s1_pixel_ff};
   assign wr_en   = advance && s1_valid_ff;

   assign fwd_hit_in = wr_en && accept &&
                       (s1_col_ff[cvw_pkg::ADDR_W-1:0] == col[cvw_pkg::ADDR_W-1:0]);

   always_comb begin
      window_in = window_ff;
      for (int i = 0; i < cvw_pkg::KSIZE; i++) begin
         window_in[i][0] = window_ff[i][1];
         window_in[i][1] = window_ff[i][2];
      end
      window_in[0][2] = above2;
      window_in[1][2] = above1;
      window_in[2][2] = s1_pixel_ff;

      meta_in.valid = s1_valid_ff && (s1_row_ff >= cvw_pkg::BORDER) &&
                      (s1_col_ff >= cvw_pkg::BORDER);
      meta_in.row   = s1_row_ff - cvw_pkg::BORDER;
      meta_in.col   = s1_col_ff - cvw_pkg::BORDER;
      meta_in.last  = (s1_row_ff == cvw_pkg::ROW_LAST) &&
                      (s1_col_ff == cvw_pkg::COL_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
         meta_ff     <= '0;
      end else if (advance) begin
         s1_valid_ff <= accept;
         fwd_hit_ff  <= fwd_hit_in;
         meta_ff     <= meta_in;
      end
      if (advance) begin
         fwd_data_ff <= wr_data;
         if (accept) begin
            s1_pixel_ff <= pixel;
            s1_row_ff   <= row;
            s1_col_ff   <= col;
         end
         if (s1_valid_ff) begin
            window_ff <= window_in;
         end
      end
   end

   assign window = window_ff;
   assign meta   = meta_ff;

endmodule

// ===== rtl/core/cvw_mac.sv =====
// nine products and per-row partial sums, two register stages
module cvw_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  cvw_pkg::window_type   window,
   input  cvw_pkg::kernel_type   kernel,
   input  cvw_pkg::meta_type     meta_in,
   output cvw_pkg::psum_type     psum,
   output cvw_pkg::meta_type     meta_out
);

   logic signed [cvw_pkg::KSIZE-1:0][cvw_pkg::KSIZE-1:0][cvw_pkg::PROD_W-1:0] prod_ff;
   logic signed [cvw_pkg::KSIZE-1:0][cvw_pkg::KSIZE-1:0][cvw_pkg::PROD_W-1:0] prod_in;
   cvw_pkg::psum_type  psum_ff;
   cvw_pkg::psum_type  psum_in;
   cvw_pkg::meta_type  meta_prod_ff;
   cvw_pkg::meta_type  meta_psum_ff;

   always_comb begin
      for (int i = 0; i < cvw_pkg::KSIZE; i++) begin
         for (int j = 0; j < cvw_pkg::KSIZE; j++) begin
            prod_in[i][j] = $signed(window[i][j]) * $signed(kernel[i][j]);
         end
      end
      for (int i = 0; i < cvw_pkg::KSIZE; i++) begin
         psum_in[i] = cvw_pkg::PSUM_W'($signed(prod_ff[i][0])) +
                      cvw_pkg::PSUM_W'($signed(prod_ff[i][1])) +
                      cvw_pkg::PSUM_W'($signed(prod_ff[i][2]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_prod_ff <= '0;
         meta_psum_ff <= '0;
      end else if (advance) begin
         meta_prod_ff <= meta_in;
         meta_psum_ff <= meta_prod_ff;
      end
      if (advance) begin
         prod_ff <= prod_in;
         psum_ff <= psum_in;
      end
   end

   assign psum     = psum_ff;
   assign meta_out = meta_psum_ff;

endmodule

// ===== rtl/core/conv3x3_valid_window_unit.sv =====
// top level of the 3x3 valid-window convolution over a pixel raster
//
// pixels enter one per beat on the req_ channel in raster order; req_frame_start
// marks row 0, column 0 of an image and resets the raster position. each pixel at
// row >= 2 and column >= 2 yields one beat on the rsp_ channel: the exact sum of
// the 3x3 window times the kernel, its position in the reduced image and a flag
// on the last result of the image. border pixels give no result.
// the kernel is loaded through csr_ writes (one 48-bit row per index); the user
// must load it while idle, as the block does not enforce this. the edge that
// accepts a pixel starts the line-store read, then the window register, the
// product register, the partial-sum register and the result register follow.
// throughput: one pixel per cycle while rsp_ready is high.
// reset clears the raster position, the kernel and the pipeline; the line store
// is not cleared, as the first two rows of every image fill it before use.
// when the receiver stalls with a result waiting, the whole pipeline holds and
// req_ready drops in the same cycle; nothing is lost or repeated.
module conv3x3_valid_window_unit (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [cvw_pkg::PIX_W-1:0] req_pixel,
   input  logic                            req_frame_start,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [cvw_pkg::FILT_W-1:0] rsp_filtered,
   output logic [cvw_pkg::CNT_W-1:0]       rsp_out_row,
   output logic [cvw_pkg::CNT_W-1:0]       rsp_out_col,
   output logic                            rsp_frame_last,

   input  logic                            csr_wr_en,
   input  logic [cvw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cvw_pkg::KROW_W-1:0]      csr_wr_data
);

   logic                         advance;
   logic                         accept;

   logic [cvw_pkg::CNT_W-1:0]    row_ff;
   logic [cvw_pkg::CNT_W-1:0]    row_in;
   logic [cvw_pkg::CNT_W-1:0]    col_ff;
   logic [cvw_pkg::CNT_W-1:0]    col_in;
   logic [cvw_pkg::CNT_W-1:0]    cur_row;
   logic [cvw_pkg::CNT_W-1:0]    cur_col;

   logic [cvw_pkg::KROW_W-1:0]   kernel_row0_ff;
   logic [cvw_pkg::KROW_W-1:0]   kernel_row1_ff;
   logic [cvw_pkg::KROW_W-1:0]   kernel_row2_ff;
   cvw_pkg::kernel_type          kernel;

   cvw_pkg::window_type          window;
   cvw_pkg::meta_type            win_meta;
   cvw_pkg::psum_type            psum;
   cvw_pkg::meta_type            psum_meta;

   logic signed [cvw_pkg::SUM_W-1:0] sum_in;
   logic                         rsp_valid_ff;
   logic [cvw_pkg::FILT_W-1:0]   rsp_filtered_ff;
   logic [cvw_pkg::CNT_W-1:0]    rsp_out_row_ff;
   logic [cvw_pkg::CNT_W-1:0]    rsp_out_col_ff;
   logic                         rsp_frame_last_ff;

   // the pipeline moves as a whole whenever the result register can take a beat
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // raster position of the pixel being accepted
   assign cur_row = req_frame_start ? '0 : row_ff;
   assign cur_col = req_frame_start ? '0 : col_ff;

   always_comb begin
      if (cur_col == cvw_pkg::COL_LAST) begin
         col_in = '0;
         row_in = (cur_row == cvw_pkg::ROW_LAST) ? '0 : cur_row + 1'b1;
      end else begin
         col_in = cur_col + 1'b1;
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_row0_ff <= '0;
         kernel_row1_ff <= '0;
         kernel_row2_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            cvw_pkg::CSR_KERNEL_ROW0: kernel_row0_ff <= csr_wr_data;
            cvw_pkg::CSR_KERNEL_ROW1: kernel_row1_ff <= csr_wr_data;
            cvw_pkg::CSR_KERNEL_ROW2: kernel_row2_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign kernel[0] = kernel_row0_ff;
   assign kernel[1] = kernel_row1_ff;
   assign kernel[2] = kernel_row2_ff;

   cvw_window u_window (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .accept  (accept),
      .pixel   (req_pixel),
      .row     (cur_row),
      .col     (cur_col),
      .window  (window),
      .meta    (win_meta)
   );

   cvw_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .window   (window),
      .kernel   (kernel),
      .meta_in  (win_meta),
      .psum     (psum),
      .meta_out (psum_meta)
   );

   // row sums are signed, so widen with sign extension
   assign sum_in = cvw_pkg::SUM_W'($signed(psum[0])) +
                   cvw_pkg::SUM_W'($signed(psum[1])) +
                   cvw_pkg::SUM_W'($signed(psum[2]));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= psum_meta.valid;
      end
      if (advance) begin
         rsp_filtered_ff   <= sum_in[cvw_pkg::FILT_W-1:0];
         rsp_out_row_ff    <= psum_meta.row;
         rsp_out_col_ff    <= psum_meta.col;
         rsp_frame_last_ff <= psum_meta.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_filtered   = rsp_filtered_ff;
   assign rsp_out_row    = rsp_out_row_ff;
   assign rsp_out_col    = rsp_out_col_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the 3x3 valid-window convolution unit
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 8;       // pipeline depth plus margin
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int RANDOM_PIXELS = 220;     // per idle phase
   localparam longint TIMEOUT_NS = 3_000_000;
   localparam logic [cvw_pkg::CSR_IDX_W-1:0] CSR_UNUSED_IDX = cvw_pkg::CSR_IDX_W'(3);

   typedef enum int {MIX_FULL, MIX_SMALL, MIX_EXTREME, MIX_RAMP} value_mix_type;

   typedef struct packed {
      logic signed [cvw_pkg::FILT_W-1:0] filtered;
      logic [cvw_pkg::CNT_W-1:0]         row;
      logic [cvw_pkg::CNT_W-1:0]         col;
      logic                              last;
   } conv_result_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic signed [cvw_pkg::PIX_W-1:0]   req_pixel = '0;
   logic                               req_frame_start = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic signed [cvw_pkg::FILT_W-1:0]  rsp_filtered;
   logic [cvw_pkg::CNT_W-1:0]          rsp_out_row;
   logic [cvw_pkg::CNT_W-1:0]          rsp_out_col;
   logic                               rsp_frame_last;
   logic                               csr_wr_en = 1'b0;
   logic [cvw_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [cvw_pkg::KROW_W-1:0]         csr_wr_data = '0;

   conv3x3_valid_window_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_filtered    (rsp_filtered),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_frame_last  (rsp_frame_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the block state
   logic [cvw_pkg::PIX_W-1:0]  line_mem [2*cvw_pkg::IMG_WIDTH];
   logic [cvw_pkg::PIX_W-1:0]  win [cvw_pkg::KSIZE][cvw_pkg::KSIZE];
   logic [cvw_pkg::KROW_W-1:0] kern_rows [cvw_pkg::KSIZE];
   int unsigned                col_pos;
   int unsigned                row_pos;

   conv_result_type due_sums [$];
   conv_result_type oldest_sum;

   int send_idle_pct;
   int recv_idle_pct;
   int unsigned rsp_hold_left;
   int errors;
   int pixels_sent;
   int sums_checked;
   int frames_closed;
   int kernel_loads;

   task automatic predict_window_sum(input logic [cvw_pkg::PIX_W-1:0] pix, input logic fs);
      int unsigned r, c;
      int i, j;
      logic [cvw_pkg::PIX_W-1:0] up1, up2;
      logic signed [cvw_pkg::PIX_W-1:0] p;
      logic signed [cvw_pkg::COEF_W-1:0] k;
      longint acc;
      conv_result_type res;
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      up1 = line_mem[c];
      up2 = line_mem[cvw_pkg::IMG_WIDTH + c];
      line_mem[cvw_pkg::IMG_WIDTH + c] = up1;
      line_mem[c] = pix;
      for (i = 0; i < cvw_pkg::KSIZE; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = pix;
      if (c == cvw_pkg::IMG_WIDTH - 1) begin
         col_pos = 0;
         row_pos = (r == cvw_pkg::IMG_HEIGHT - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
      if (r >= 2 && c >= 2) begin
         acc = 0;
         for (i = 0; i < cvw_pkg::KSIZE; i++)
            for (j = 0; j < cvw_pkg::KSIZE; j++) begin
               p = win[i][j];
               k = kern_rows[i][j*cvw_pkg::COEF_W +: cvw_pkg::COEF_W];
               acc += longint'(p) * longint'(k);
            end
         res.filtered = acc[cvw_pkg::FILT_W-1:0];
         res.row = cvw_pkg::CNT_W'(r - 2);
         res.col = cvw_pkg::CNT_W'(c - 2);
         res.last = (r == cvw_pkg::IMG_HEIGHT - 1) && (c == cvw_pkg::IMG_WIDTH - 1);
         due_sums.push_back(res);
      end
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_pixel(input logic [cvw_pkg::PIX_W-1:0] pix, input logic fs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      req_frame_start <= fs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_window_sum(pix, fs);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic wait_sums_drained();
      req_valid <= 1'b0;
      while (due_sums.size() != 0) @(negedge clock);
   endtask

   // border pixels leave no result, so give them time to leave the pipeline
   task automatic settle_for_config();
      wait_sums_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [cvw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [cvw_pkg::KROW_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      if (idx <= cvw_pkg::CSR_KERNEL_ROW2)
         kern_rows[idx] = data;
   endtask

   task automatic load_kernel(input logic [cvw_pkg::KROW_W-1:0] k0,
                              input logic [cvw_pkg::KROW_W-1:0] k1,
                              input logic [cvw_pkg::KROW_W-1:0] k2);
      settle_for_config();
      write_csr(cvw_pkg::CSR_KERNEL_ROW0, k0);
      write_csr(cvw_pkg::CSR_KERNEL_ROW1, k1);
      write_csr(cvw_pkg::CSR_KERNEL_ROW2, k2);
      kernel_loads++;
   endtask

   function automatic logic [cvw_pkg::PIX_W-1:0] rand_sample(input value_mix_type mix);
      case (mix)
         MIX_SMALL: return cvw_pkg::PIX_W'($urandom_range(16)) - cvw_pkg::PIX_W'(8);
         MIX_EXTREME:
            case ($urandom_range(3))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'hffff;
               default: return 16'h0000;
            endcase
         default: return cvw_pkg::PIX_W'($urandom_range(16'hffff));
      endcase
   endfunction

   function automatic logic [cvw_pkg::KROW_W-1:0] rand_kernel_row(input value_mix_type mix);
      return {rand_sample(mix), rand_sample(mix), rand_sample(mix)};
   endfunction

   // one frame prefix: two full rows, then extra further pixels in raster order
   task automatic send_frame_prefix(input int extra, input value_mix_type mix);
      int n, r, c;
      logic [cvw_pkg::PIX_W-1:0] pix;
      for (n = 0; n < 2*cvw_pkg::IMG_WIDTH + extra; n++) begin
         r = n / cvw_pkg::IMG_WIDTH;
         c = n % cvw_pkg::IMG_WIDTH;
         case (mix)
            MIX_EXTREME: pix = (c < 5) ? 16'h8000 : 16'h7fff;
            MIX_RAMP: pix = cvw_pkg::PIX_W'(r * 100 + c * 3 - 40);
            default: pix = rand_sample(mix);
         endcase
         send_pixel(pix, n == 0);
      end
   endtask

   // largest and smallest sums, kernel orientation, new frame in mid-row
   task automatic test_extreme_sums();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_kernel({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
      send_frame_prefix(10, MIX_EXTREME);
      load_kernel({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}});
      send_frame_prefix(10, MIX_EXTREME);
      load_kernel({16'h8000, 16'h7fff, 16'h8000}, {16'h7fff, 16'h8000, 16'h7fff},
                  {16'hffff, 16'h0001, 16'h0000});
      send_frame_prefix(10, MIX_EXTREME);
      // distinct coefficients and a pixel ramp catch flipped rows or columns
      load_kernel({16'd3, 16'd2, 16'd1}, {16'd30, 16'd20, 16'd10},
                  {16'd300, 16'd200, 16'hff9c});
      send_frame_prefix(12, MIX_RAMP);
   endtask

   // writes to the spare index must leave the kernel alone
   task automatic test_unused_index();
      settle_for_config();
      write_csr(CSR_UNUSED_IDX, {cvw_pkg::KROW_W{1'b1}});
      write_csr(CSR_UNUSED_IDX, {cvw_pkg::KROW_W{1'b0}});
      send_frame_prefix(8, MIX_FULL);
   endtask

   // receiver stalls long enough for the block to fill and refuse pixels
   task automatic test_output_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_kernel(rand_kernel_row(MIX_FULL), rand_kernel_row(MIX_FULL),
                  rand_kernel_row(MIX_FULL));
      rsp_hold_left = RSP_HOLD_CYCLES;
      send_frame_prefix(150, MIX_FULL);
      wait_sums_drained();
   endtask

   task automatic test_random_stream(input int s_idle, input int r_idle);
      int sent, seg_len, pick, n;
      value_mix_type mix;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            mix = value_mix_type'($urandom_range(MIX_EXTREME));
            load_kernel(rand_kernel_row(mix), rand_kernel_row(mix), rand_kernel_row(mix));
            if ($urandom_range(3) == 0)
               write_csr(CSR_UNUSED_IDX, rand_kernel_row(MIX_FULL));
         end
         mix = value_mix_type'($urandom_range(MIX_EXTREME));
         if (pick < 80) begin
            seg_len = 2*cvw_pkg::IMG_WIDTH + $urandom_range(3, cvw_pkg::IMG_WIDTH);
            for (n = 0; n < seg_len; n++)
               send_pixel(rand_sample(mix), n == 0);
         end else begin
            // runs on from wherever the raster is, with stray frame starts
            seg_len = $urandom_range(1, 80);
            for (n = 0; n < seg_len; n++)
               send_pixel(rand_sample(mix), $urandom_range(19) == 0);
         end
         sent += seg_len;
         if ($urandom_range(9) == 0)
            wait_sums_drained();
      end
   endtask

   // receiver: random stalls, or a long counted hold-off
   always @(negedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_sums.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing pending: filtered %0d row %0d col %0d",
                     $realtime, rsp_filtered, rsp_out_row, rsp_out_col);
         end else begin
            oldest_sum = due_sums.pop_front();
            sums_checked++;
            if (rsp_frame_last)
               frames_closed++;
            if (rsp_filtered !== oldest_sum.filtered) begin
               errors++;
               $display("%0t: filtered expected %0d actual %0d", $realtime,
                        oldest_sum.filtered, rsp_filtered);
            end
            if (rsp_out_row !== oldest_sum.row) begin
               errors++;
               $display("%0t: out_row expected %0d actual %0d", $realtime,
                        oldest_sum.row, rsp_out_row);
            end
            if (rsp_out_col !== oldest_sum.col) begin
               errors++;
               $display("%0t: out_col expected %0d actual %0d", $realtime,
                        oldest_sum.col, rsp_out_col);
            end
            if (rsp_frame_last !== oldest_sum.last) begin
               errors++;
               $display("%0t: frame_last expected %0d actual %0d", $realtime,
                        oldest_sum.last, rsp_frame_last);
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", due_sums.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      foreach (line_mem[n]) line_mem[n] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      foreach (kern_rows[i]) kern_rows[i] = '0;
      col_pos = 0;
      row_pos = 0;
      rsp_hold_left = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      errors = 0;
      pixels_sent = 0;
      sums_checked = 0;
      frames_closed = 0;
      kernel_loads = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_extreme_sums();
      test_unused_index();
      test_output_stall();
      test_random_stream(31, 73);
      test_random_stream(73, 31);
      test_random_stream(0, 0);

      wait_sums_drained();
      repeat (SETTLE_CYCLES * 3) @(negedge clock);
      if (due_sums.size() != 0) begin
         errors++;
         $display("%0t: %0d expected results never arrived", $realtime, due_sums.size());
      end
      $display("sent %0d pixels, checked %0d sums over %0d kernel loads, %0d frame ends",
               pixels_sent, sums_checked, kernel_loads, frames_closed);
      $display("covered extreme sums, spare index writes, a long output stall and stray frame starts");
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
